>>> hdl/radix_convert_decimal_coded_assert.svh
// Assertion macros shared by the radix conversion block
`ifndef RADIX_CONVERT_DECIMAL_CODED_ASSERT_SVH
`define RADIX_CONVERT_DECIMAL_CODED_ASSERT_SVH

// same-cycle implication
`define RCDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcdc assertion failed");

// next-cycle implication
`define RCDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcdc assertion failed");

`endif

>>> hdl/rcdc_pkg.sv
// Package: constants, types and tables of the radix conversion block
package rcdc_pkg;

    localparam int IN_DIGITS  = 9;
    localparam int OUT_DIGITS = 19;

    localparam int IN_W     = 30;
    localparam int VAL_W    = 30;
    localparam int OUT_W    = 64;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 4;
    localparam int DIGIT_W  = 4;
    localparam int RECIP_W  = 32;
    localparam int PROD_W   = VAL_W + RECIP_W;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W    = $clog2(IN_DIGITS + 1);
    localparam int NDIG_W   = $clog2(OUT_DIGITS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_BASE = 1'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [BASE_W-1:0] SRC_BASE_RST = 4'd10;
    localparam logic [BASE_W-1:0] TGT_BASE_RST = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MIN     = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MAX     = 4'd10;

    // x / 10 == (x * RECIP10) >> RECIP10_SH for any 32-bit x
    localparam logic [RECIP_W-1:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int                 RECIP10_SH = 35;
    localparam int                 RECIP_SH   = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIG_MUL,
        S_DIG_ACC,
        S_CNV_MUL,
        S_CNV_DIV,
        S_PACK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic dig_mul;
        logic dig_acc;
        logic cnv_mul;
        logic cnv_div;
        logic pack;
        logic set_ovf;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic bases_ok;
        logic val_zero;
        logic out_free;
    } t_stat;

    // floor(2^32 / b); the quotient estimate is low by at most one
    function automatic logic [RECIP_W-1:0] recip_of(input logic [BASE_W-1:0] b);
        logic [RECIP_W-1:0] m;
        unique case (b)
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            4'd9:    m = 32'h1C71_C71C;
            4'd10:   m = 32'h1999_9999;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/rcdc_if.sv
// Interfaces: request and response channels of the radix conversion block
interface rcdc_in_if;
    import rcdc_pkg::*;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] coded_number;

    modport source (output valid, output coded_number, input ready);
    modport sink   (input valid, input coded_number, output ready);
endinterface

interface rcdc_out_if;
    import rcdc_pkg::*;
    logic                valid;
    logic                ready;
    logic [OUT_W-1:0]    converted_number;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output converted_number, output status, input ready);
    modport sink   (input valid, input converted_number, input status, output ready);
endinterface

>>> hdl/radix_convert_decimal_coded.sv
// Top level: radix conversion of decimal-coded numbers between bases 2 and 10
// One request takes a number whose nine low decimal digits are digits in the source base
// and returns its value written in the target base, one decimal digit per target digit,
// with status 0 ok, 1 base outside 2..10, 2 more than 19 output digits. A request steps
// through the input digits, then through the output digits, then packs the output digits
// into the result; every input and output digit step goes through the single 30x32
// multiplier. A bad base goes straight to the result hand-off. The next request is taken
// as soon as the result sits in the output register, even if it has not been taken yet.
module radix_convert_decimal_coded (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcdc_pkg::BASE_W-1:0]    i_cfg_wdata,
    rcdc_in_if.sink                        i_req,
    rcdc_out_if.source                     o_rsp
);
    import rcdc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    rcdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rcdc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_coded_number     (i_req.coded_number),
        .i_out_ready        (o_rsp.ready),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_out_valid        (o_rsp.valid),
        .o_converted_number (o_rsp.converted_number),
        .o_status           (o_rsp.status)
    );

    assign i_req.ready = req_ready;

endmodule

>>> hdl/rcdc_datapath.sv
// Datapath: config registers, shared multiplier, digit registers, result packing
module rcdc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcdc_pkg::BASE_W-1:0]    i_cfg_wdata,
    input  logic [rcdc_pkg::IN_W-1:0]      i_coded_number,
    input  logic                           i_out_ready,
    input  rcdc_pkg::t_cmd                 i_cmd,
    output rcdc_pkg::t_stat                o_stat,
    output logic                           o_out_valid,
    output logic [rcdc_pkg::OUT_W-1:0]     o_converted_number,
    output logic [rcdc_pkg::STATUS_W-1:0]  o_status
);
    import rcdc_pkg::*;

    logic [BASE_W-1:0]   r_src_base, r_tgt_base;
    logic [IN_W-1:0]     r_x, n_x;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [VAL_W-1:0]    r_weight, n_weight;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [DIGIT_W-1:0]  r_dig [OUT_DIGITS];
    logic [DIGIT_W-1:0]  n_dig [OUT_DIGITS];
    logic [OUT_W-1:0]    r_res, n_res;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_conv;
    logic [STATUS_W-1:0] r_out_status;

    logic                bases_ok;
    logic [VAL_W-1:0]    mul_a;
    logic [RECIP_W-1:0]  mul_b;
    logic [IN_W-1:0]     q10, q10_x10, rem10;
    logic [DIGIT_W-1:0]  d10;
    logic [VAL_W-1:0]    q0, q0_xb, rem_raw, qb;
    logic [4:0]          rb5, rb_fix;
    logic [DIGIT_W-1:0]  db;

    assign bases_ok = (r_src_base >= BASE_MIN) && (r_src_base <= BASE_MAX)
                   && (r_tgt_base >= BASE_MIN) && (r_tgt_base <= BASE_MAX);

    // shared multiplier operands
    assign mul_a = i_cmd.cnv_mul ? r_val : VAL_W'(r_x);
    assign mul_b = i_cmd.cnv_mul ? recip_of(r_tgt_base) : RECIP10;

    // decimal digit split
    assign q10     = IN_W'(r_prod >> RECIP10_SH);
    assign q10_x10 = (q10 << 3) + (q10 << 1);
    assign rem10   = r_x - q10_x10;
    assign d10     = rem10[DIGIT_W-1:0];

    // target base digit split with one correction step
    assign q0      = r_prod[PROD_W-1 -: VAL_W];
    assign q0_xb   = VAL_W'(q0 * VAL_W'(r_tgt_base));
    assign rem_raw = r_val - q0_xb;
    assign rb5     = rem_raw[4:0];

    always_comb begin
        if (rb5 >= {1'b0, r_tgt_base}) begin
            qb     = q0 + VAL_W'(1);
            rb_fix = rb5 - {1'b0, r_tgt_base};
        end else begin
            qb     = q0;
            rb_fix = rb5;
        end
    end
    assign db = rb_fix[DIGIT_W-1:0];

    always_comb begin
        n_x      = r_x;
        n_val    = r_val;
        n_weight = r_weight;
        n_prod   = r_prod;
        n_res    = r_res;
        n_status = r_status;
        n_dig    = r_dig;
        if (i_cmd.load) begin
            n_x      = i_coded_number;
            n_val    = '0;
            n_weight = VAL_W'(1);
            n_res    = '0;
            n_status = bases_ok ? ST_OK : ST_BAD_BASE;
        end
        if (i_cmd.dig_mul || i_cmd.cnv_mul) begin
            n_prod = {{(PROD_W-VAL_W){1'b0}}, mul_a} * {{(PROD_W-RECIP_W){1'b0}}, mul_b};
        end
        if (i_cmd.dig_acc) begin
            n_x      = q10;
            n_val    = r_val + VAL_W'(r_weight * VAL_W'(d10));
            n_weight = VAL_W'(r_weight * VAL_W'(r_src_base));
        end
        if (i_cmd.cnv_div) begin
            n_val    = qb;
            n_dig[0] = db;
            for (int i = 1; i < OUT_DIGITS; i++) begin
                n_dig[i] = r_dig[i-1];
            end
        end
        if (i_cmd.pack) begin
            n_res = (r_res << 3) + (r_res << 1) + OUT_W'(r_dig[0]);
            for (int i = 0; i < OUT_DIGITS - 1; i++) begin
                n_dig[i] = r_dig[i+1];
            end
            n_dig[OUT_DIGITS-1] = '0;
        end
        if (i_cmd.set_ovf) begin
            n_status = ST_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_val    <= n_val;
        r_weight <= n_weight;
        r_prod   <= n_prod;
        r_res    <= n_res;
        r_status <= n_status;
        r_dig    <= n_dig;
        if (i_cmd.emit) begin
            r_out_conv   <= r_res;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base  <= SRC_BASE_RST;
            r_tgt_base  <= TGT_BASE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SRC_BASE: r_src_base <= i_cfg_wdata;
                    CFG_TGT_BASE: r_tgt_base <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.bases_ok = bases_ok;
    assign o_stat.val_zero = (r_val == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_converted_number = r_out_conv;
    assign o_status           = r_out_status;

endmodule

>>> hdl/rcdc_ctrl.sv
// Controller: sequences digit split, base conversion, packing and result hand-off
`include "radix_convert_decimal_coded_assert.svh"

module rcdc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  rcdc_pkg::t_stat i_stat,
    output rcdc_pkg::t_cmd  o_cmd
);
    import rcdc_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic              accept;
    logic              last_in_digit;
    logic              out_full;

    assign accept        = i_req_valid && (r_state == S_IDLE);
    assign last_in_digit = (r_cnt == CNT_W'(IN_DIGITS - 1));
    assign out_full      = (r_ndig == NDIG_W'(OUT_DIGITS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_stat.bases_ok ? S_DIG_MUL : S_DONE;
                end
            end
            S_DIG_MUL: n_state = S_DIG_ACC;
            S_DIG_ACC: n_state = last_in_digit ? S_CNV_MUL : S_DIG_MUL;
            S_CNV_MUL: begin
                if (i_stat.val_zero) begin
                    n_state = S_PACK;
                end else if (out_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CNV_DIV;
                end
            end
            S_CNV_DIV: n_state = S_CNV_MUL;
            S_PACK:    n_state = (r_ndig == '0) ? S_DONE : S_PACK;
            S_DONE:    n_state = i_stat.out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_DIG_MUL: o_cmd.dig_mul = 1'b1;
            S_DIG_ACC: o_cmd.dig_acc = 1'b1;
            S_CNV_MUL: begin
                if (!i_stat.val_zero) begin
                    o_cmd.set_ovf = out_full;
                    o_cmd.cnv_mul = !out_full;
                end
            end
            S_CNV_DIV: o_cmd.cnv_div = 1'b1;
            S_PACK:    o_cmd.pack = (r_ndig != '0);
            S_DONE:    o_cmd.emit = i_stat.out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_ndig = r_ndig;
        if (accept) begin
            n_cnt  = '0;
            n_ndig = '0;
        end
        if (o_cmd.dig_acc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (o_cmd.cnv_div) begin
            n_ndig = r_ndig + NDIG_W'(1);
        end
        if (o_cmd.pack) begin
            n_ndig = r_ndig - NDIG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ndig  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ndig  <= n_ndig;
        end
    end

    `RCDC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, accept, (r_state == S_DIG_MUL || r_state == S_DONE))
    `RCDC_ASSERT_IMP(a_ndig_bound, i_clk, i_rst_n, 1'b1, (r_ndig <= NDIG_W'(OUT_DIGITS)))
    `RCDC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, (r_state == S_DIG_ACC), (r_cnt < CNT_W'(IN_DIGITS)))
    `RCDC_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free)

endmodule
